>>> src/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared constants, types and compare helpers for the serial marker deframer.
// ----------------------------------------------------------------------------
package smd_pkg;

  // Frame limits
  localparam int LENGTH_LIMIT = 63;
  localparam int MARKER_MAX   = 8;
  localparam int MARKER_BYTES = 8;                     // bytes in a 64-bit marker word
  localparam int MK_IDX_W     = $clog2(MARKER_BYTES);
  localparam int BUF_DEPTH    = 64;
  localparam int ADDR_W       = $clog2(BUF_DEPTH);
  localparam int FILL_W       = ADDR_W + 1;
  localparam int LEN_W        = 4;
  localparam int MARKER_W     = 8 * MARKER_BYTES;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  // Result status codes
  localparam logic [2:0] ST_PAYLOAD      = 3'd0;
  localparam logic [2:0] ST_EMPTY        = 3'd1;
  localparam logic [2:0] ST_END_NO_START = 3'd2;
  localparam logic [2:0] ST_START_NO_END = 3'd3;
  localparam logic [2:0] ST_OVERFLOW     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_START_LENGTH = 2'd1;
  localparam logic [1:0] REG_END_MARKER   = 2'd2;
  localparam logic [1:0] REG_END_LENGTH   = 2'd3;

  // Configuration reset values
  localparam logic [MARKER_W-1:0] START_MARKER_RST = MARKER_W'(60);
  localparam logic [LEN_W-1:0]    START_LENGTH_RST = LEN_W'(1);
  localparam logic [MARKER_W-1:0] END_MARKER_RST   = MARKER_W'(62);
  localparam logic [LEN_W-1:0]    END_LENGTH_RST   = LEN_W'(1);

  typedef logic [7:0] byte_t;
  typedef byte_t [MARKER_BYTES-1:0] marker_bytes_t;

  typedef struct packed {
    logic [MARKER_W-1:0] start_marker;
    logic [LEN_W-1:0]    start_length;
    logic [MARKER_W-1:0] end_marker;
    logic [LEN_W-1:0]    end_length;
  } cfg_t;

  // One queued job: a status result (optionally followed by overflow) or a drain
  typedef struct packed {
    logic              drain;
    logic [2:0]        code;
    logic              ovf_after;
    logic [ADDR_W-1:0] base;
    logic [FILL_W-1:0] len;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STATUS,
    BK_OVF,
    BK_DRAIN_RD,
    BK_DRAIN_WR
  } back_state_t;

  // Clamp a marker length into 1..MARKER_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MARKER_MAX)) begin
      r = LEN_W'(MARKER_MAX);
    end
    return r;
  endfunction

  // First len bytes of b equal the marker
  function automatic logic prefix_match(input marker_bytes_t b, input marker_bytes_t m,
                                        input logic [LEN_W-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (LEN_W'(i) < len && b[i] != m[i]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Newest len bytes (b[0] newest) equal the marker in arrival order
  function automatic logic suffix_match(input marker_bytes_t b, input marker_bytes_t m,
                                        input logic [LEN_W-1:0] len);
    logic             ok;
    logic [LEN_W-1:0] idx;
    ok = 1'b1;
    for (int j = 0; j < MARKER_BYTES; j++) begin
      idx = len - LEN_W'(j) - LEN_W'(1);
      if (LEN_W'(j) < len && b[j] != m[idx[MK_IDX_W-1:0]]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

>>> src/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/smd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// smd_cmd_fifo
// Short command queue between the classifying front and the result back end.
// ----------------------------------------------------------------------------
module smd_cmd_fifo
  import smd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign dout  = q[rd_ptr];
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

>>> src/smd_front.sv
// ----------------------------------------------------------------------------
// smd_front
// Accepts received bytes, appends them to the frame buffer and classifies the
// buffer against the start and end markers, queuing one job per outcome.
// ----------------------------------------------------------------------------
module smd_front
  import smd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  logic [7:0]        rx_byte,
  input  logic              fifo_full,
  output logic              push,
  output cmd_t              cmd,
  input  logic              drain_done,
  output marker_bytes_t     head_bytes,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata
);

  logic [FILL_W-1:0] fill, fill_next;
  logic              drain_busy;
  marker_bytes_t     head, head_next;    // buffer positions 0..7
  marker_bytes_t     tail, tail_next;    // newest bytes, tail[0] newest

  logic              accept;
  logic [LEN_W-1:0]  slen, elen;
  logic [FILL_W-1:0] slen_x, elen_x, fill_inc, plen;
  marker_bytes_t     start_m, end_m;
  marker_bytes_t     head_n, tail_n, head_r, tail_r;
  logic              check, end_pre, start_pre, restart, frame, over;

  // Hold input while a drain owns the buffer or the queue is full
  assign rx_ready = !drain_busy && !fifo_full;
  assign accept   = rx_valid && rx_ready;

  // Append the byte into the buffer memory
  assign ram_we     = accept;
  assign ram_waddr  = fill[ADDR_W-1:0];
  assign ram_wdata  = rx_byte;
  assign head_bytes = head;

  // Buffer view with the new byte in place
  always_comb begin
    logic [LEN_W-1:0] idx;
    slen     = eff_len(cfg.start_length);
    elen     = eff_len(cfg.end_length);
    slen_x   = FILL_W'(slen);
    elen_x   = FILL_W'(elen);
    start_m  = marker_bytes_t'(cfg.start_marker);
    end_m    = marker_bytes_t'(cfg.end_marker);
    fill_inc = fill + 1'b1;
    plen     = fill_inc - slen_x - elen_x;

    head_n = head;
    if (fill < FILL_W'(MARKER_BYTES)) begin
      head_n[fill[MK_IDX_W-1:0]] = rx_byte;
    end
    tail_n = {tail[MARKER_BYTES-2:0], rx_byte};

    // Restart images: buffer holds just the start marker
    head_r = head_n;
    tail_r = tail_n;
    for (int k = 0; k < MARKER_BYTES; k++) begin
      idx = slen - LEN_W'(k) - LEN_W'(1);
      if (LEN_W'(k) < slen) begin
        head_r[k] = start_m[k];
        tail_r[k] = start_m[idx[MK_IDX_W-1:0]];
      end
    end

    check     = fill_inc >= slen_x;
    end_pre   = (fill_inc >= elen_x) && prefix_match(head_n, end_m, elen);
    start_pre = prefix_match(head_n, start_m, slen);
    restart   = (fill_inc > slen_x) && suffix_match(tail_n, start_m, slen);
    frame     = (fill_inc >= slen_x + elen_x) && suffix_match(tail_n, end_m, elen);
    over      = fill_inc > FILL_W'(LENGTH_LIMIT);
  end

  // Classify the buffer and pick the job
  always_comb begin
    fill_next = fill;
    head_next = head;
    tail_next = tail;
    push      = 1'b0;
    cmd       = '0;
    cmd.code  = ST_PAYLOAD;
    if (accept) begin
      fill_next = fill_inc;
      head_next = head_n;
      tail_next = tail_n;
      if (check) begin
        if (end_pre) begin
          push      = 1'b1;
          cmd.code  = ST_END_NO_START;
          fill_next = '0;
        end else if (start_pre) begin
          if (restart) begin
            push      = 1'b1;
            cmd.code  = ST_START_NO_END;
            head_next = head_r;
            tail_next = tail_r;
            if (slen_x > FILL_W'(LENGTH_LIMIT)) begin
              cmd.ovf_after = 1'b1;
              fill_next     = '0;
            end else begin
              fill_next = slen_x;
            end
          end else if (frame) begin
            push      = 1'b1;
            fill_next = '0;
            if (plen == '0) begin
              cmd.code = ST_EMPTY;
            end else begin
              cmd.drain = 1'b1;
              cmd.base  = ADDR_W'(slen);
              cmd.len   = plen;
            end
          end else if (over) begin
            push      = 1'b1;
            cmd.code  = ST_OVERFLOW;
            fill_next = '0;
          end
        end else begin
          fill_next = '0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      drain_busy <= 1'b0;
    end else begin
      fill <= fill_next;
      if (push && cmd.drain) begin
        drain_busy <= 1'b1;
      end else if (drain_done) begin
        drain_busy <= 1'b0;
      end
    end
  end

  // Marker windows
  always_ff @(posedge clk) begin
    head <= head_next;
    tail <= tail_next;
  end

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    push && cmd.drain |=> !rx_ready)
    else $error("input not held after a drain was queued");

  a_fill_in_limit: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(LENGTH_LIMIT))
    else $error("fill count above length limit");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept && !fifo_full)
    else $error("job queued without an accepted byte");

endmodule

>>> src/smd_back.sv
// ----------------------------------------------------------------------------
// smd_back
// Executes queued jobs: status results and payload drains from the buffer,
// through a registered output stage.
// ----------------------------------------------------------------------------
module smd_back
  import smd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fifo_empty,
  input  cmd_t              fifo_head,
  output logic              pop,
  input  marker_bytes_t     head_bytes,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              drain_done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        payload_byte,
  output logic [2:0]        status,
  output logic              last
);

  back_state_t       state, state_next;
  logic [2:0]        code;
  logic              ovf_after;
  logic [ADDR_W-1:0] rd_addr;
  logic [FILL_W-1:0] remain;

  logic              slot_free;
  logic              emit;
  logic              advance;
  logic [7:0]        emit_byte;
  logic [2:0]        emit_status;
  logic              emit_last;
  logic              final_byte;

  assign slot_free  = !out_valid || out_ready;
  assign final_byte = (remain == FILL_W'(1));
  assign ram_raddr  = rd_addr;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          state_next = fifo_head.drain ? BK_DRAIN_RD : BK_STATUS;
        end
      end
      BK_STATUS: begin
        if (slot_free) begin
          state_next = ovf_after ? BK_OVF : BK_IDLE;
        end
      end
      BK_OVF: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_DRAIN_RD: begin
        state_next = BK_DRAIN_WR;
      end
      BK_DRAIN_WR: begin
        if (slot_free) begin
          state_next = final_byte ? BK_IDLE : BK_DRAIN_RD;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    advance     = 1'b0;
    ram_re      = 1'b0;
    drain_done  = 1'b0;
    emit_byte   = '0;
    emit_status = ST_PAYLOAD;
    emit_last   = 1'b0;
    case (state)
      BK_IDLE: begin
        pop = !fifo_empty;
      end
      BK_STATUS: begin
        emit        = slot_free;
        emit_status = code;
        emit_last   = !ovf_after;
      end
      BK_OVF: begin
        emit        = slot_free;
        emit_status = ST_OVERFLOW;
        emit_last   = 1'b1;
      end
      BK_DRAIN_RD: begin
        ram_re = 1'b1;
      end
      BK_DRAIN_WR: begin
        emit        = slot_free;
        advance     = slot_free;
        drain_done  = slot_free && final_byte;
        emit_status = ST_PAYLOAD;
        emit_last   = final_byte;
        // The first marker-width positions live in the head window
        if (rd_addr < ADDR_W'(MARKER_BYTES)) begin
          emit_byte = head_bytes[rd_addr[MK_IDX_W-1:0]];
        end else begin
          emit_byte = ram_rdata;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Job registers, drain address and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      code      <= fifo_head.code;
      ovf_after <= fifo_head.ovf_after;
      rd_addr   <= fifo_head.base;
      remain    <= fifo_head.len;
    end else if (advance) begin
      rd_addr <= rd_addr + 1'b1;
      remain  <= remain - 1'b1;
    end
    if (emit) begin
      payload_byte <= emit_byte;
      status       <= emit_status;
      last         <= emit_last;
    end
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DRAIN_WR || state == BK_DRAIN_RD) |-> remain != '0)
    else $error("drain running with no bytes left");

  a_drain_done_idle: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> state == BK_IDLE)
    else $error("drain finished but back end not idle");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == BK_STATUS || state == BK_DRAIN_RD))
    else $error("popped job did not start");

endmodule

>>> src/serial_marker_deframer_core.sv
// ----------------------------------------------------------------------------
// serial_marker_deframer_core
// Start/end marker deframer for a byte-serial receive stream.
// ----------------------------------------------------------------------------
// A received byte is taken whenever no payload drain is pending and the
// two-entry job queue has room. The front appends it to a 64-byte buffer
// memory, compares the head and tail windows against the markers in the same
// cycle and queues at most one job. The back end picks up each job in its
// idle state and finishes it before it takes the next. Status results (empty
// message, end without start, start without end, overflow) leave through the
// output register. Once the queue is full, bytes are held until the back end
// picks up a job. After a completed frame with payload, rx_ready stays low
// until the last payload byte is loaded into the output register. Each
// payload byte takes a buffer-memory read state and then an output load
// state, which waits while the output is stalled. The buffer memory needs no
// clearing pass after reset. Configuration writes are taken at any time but
// are meant for idle periods.
// ----------------------------------------------------------------------------
module serial_marker_deframer_core
  import smd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [MARKER_W-1:0] cfg_data,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          payload_byte,
  output logic [2:0]          status,
  output logic                last
);

  cfg_t              cfg;
  logic              push, pop, fifo_full, fifo_empty, drain_done;
  cmd_t              cmd, fifo_head;
  marker_bytes_t     head_bytes;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.start_length <= START_LENGTH_RST;
      cfg.end_marker   <= END_MARKER_RST;
      cfg.end_length   <= END_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_MARKER: cfg.start_marker <= cfg_data;
        REG_START_LENGTH: cfg.start_length <= cfg_data[LEN_W-1:0];
        REG_END_MARKER:   cfg.end_marker   <= cfg_data;
        REG_END_LENGTH:   cfg.end_length   <= cfg_data[LEN_W-1:0];
        default: begin
          cfg.start_length <= cfg.start_length;
        end
      endcase
    end
  end

  smd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .fifo_full  (fifo_full),
    .push       (push),
    .cmd        (cmd),
    .drain_done (drain_done),
    .head_bytes (head_bytes),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  smd_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd),
    .pop   (pop),
    .dout  (fifo_head),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  smd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fifo_empty   (fifo_empty),
    .fifo_head    (fifo_head),
    .pop          (pop),
    .head_bytes   (head_bytes),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .drain_done   (drain_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .status       (status),
    .last         (last)
  );

endmodule
